// ----- hdl/ssd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package ssd_pkg;

    localparam int TEXT_DEPTH = 32;
    localparam int NUM_DIGITS = 4;
    localparam int TEXT_AW    = $clog2(TEXT_DEPTH);
    localparam int DIGIT_W    = $clog2(NUM_DIGITS);
    localparam int BANK_DEPTH = TEXT_DEPTH / NUM_DIGITS;
    localparam int BANK_AW    = $clog2(BANK_DEPTH);
    localparam int SYM_W      = 8;
    localparam int CMD_W      = 2;
    localparam int SLOT_W     = 5;
    localparam int DELAY_W    = 8;
    localparam int LEN_W      = 6;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    localparam logic [DELAY_W-1:0] DELAY_RST  = 8'd33;
    localparam logic [LEN_W-1:0]   LENGTH_RST = 6'd20;

    typedef logic [SYM_W-1:0] t_sym;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK     = 2'd0,
        CMD_TEXT_WR  = 2'd1,
        CMD_START    = 2'd2,
        CMD_DIGIT_WR = 2'd3
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SCROLL_DELAY  = 1'b0,
        CFG_SCROLL_LENGTH = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic                                 we;
        logic [DIGIT_W-1:0]                   wbank;
        logic [BANK_AW-1:0]                   waddr;
        t_sym                                 wdata;
        logic                                 re;
        logic [NUM_DIGITS-1:0][BANK_AW-1:0]   raddr;
    } t_mem_req;

    typedef struct packed {
        logic               tick;
        logic               step;
        logic               dwrite;
        logic               scrolling;
        logic [DIGIT_W-1:0] digit;
        logic [DIGIT_W-1:0] rot;
        logic [DIGIT_W-1:0] dslot;
        t_sym               symbol;
    } t_stage;

endpackage

`default_nettype wire

// ----- hdl/ssd_in_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface ssd_in_if;
    logic                        valid;
    logic                        ready;
    logic [ssd_pkg::CMD_W-1:0]   cmd;
    logic [ssd_pkg::SLOT_W-1:0]  slot;
    logic [ssd_pkg::SYM_W-1:0]   symbol;

    modport source (output valid, output cmd, output slot, output symbol, input ready);
    modport sink   (input valid, input cmd, input slot, input symbol, output ready);
endinterface

`default_nettype wire

// ----- hdl/ssd_out_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface ssd_out_if;
    logic                         valid;
    logic                         ready;
    logic [ssd_pkg::DIGIT_W-1:0]  digit_index;
    logic [ssd_pkg::SYM_W-1:0]    segments;
    logic                         scrolling;

    modport source (output valid, output digit_index, output segments, output scrolling,
                    input ready);
    modport sink   (input valid, input digit_index, input segments, input scrolling,
                    output ready);
endinterface

`default_nettype wire

// ----- hdl/ssd_bank_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ssd_bank_ram (
    input  wire logic                         i_clk,
    input  wire logic                         i_we,
    input  wire logic [ssd_pkg::BANK_AW-1:0]  i_waddr,
    input  wire ssd_pkg::t_sym                i_wdata,
    input  wire logic                         i_re,
    input  wire logic [ssd_pkg::BANK_AW-1:0]  i_raddr,
    output ssd_pkg::t_sym                     o_rdata
);

    ssd_pkg::t_sym r_mem [ssd_pkg::BANK_DEPTH];
    ssd_pkg::t_sym r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- hdl/ssd_scroll_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ssd_scroll_ctrl (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    ssd_in_if.sink                               i_item,
    input  wire logic                            i_cfg_we,
    input  wire logic [ssd_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [ssd_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  wire logic                            i_b_free,
    output logic                                 o_a_move,
    output ssd_pkg::t_mem_req                    o_mem,
    output ssd_pkg::t_stage                      o_stage
);

    localparam int TEXT_AW = ssd_pkg::TEXT_AW;
    localparam int DIGIT_W = ssd_pkg::DIGIT_W;
    localparam int LEN_W   = ssd_pkg::LEN_W;
    localparam int DELAY_W = ssd_pkg::DELAY_W;

    logic                          r_in_vld;
    ssd_pkg::t_cmd                 r_cmd;
    logic [ssd_pkg::SLOT_W-1:0]    r_slot;
    ssd_pkg::t_sym                 r_symbol;

    logic [DELAY_W-1:0]            r_scroll_delay;
    logic [LEN_W-1:0]              r_scroll_length;

    logic [TEXT_AW-1:0]            r_scroll_pos, n_scroll_pos;
    logic [DELAY_W-1:0]            r_pause_count, n_pause_count;
    logic                          r_scroll_on, n_scroll_on;
    logic [DIGIT_W-1:0]            r_mux_digit, n_mux_digit;

    logic [DELAY_W-1:0]            pause_inc;
    logic [LEN_W-1:0]              eff_len;
    logic [LEN_W-1:0]              end_pos;
    logic [LEN_W-1:0]              pos_inc;
    logic                          is_tick;
    logic                          do_step;
    logic                          a_move;

    assign a_move       = r_in_vld && i_b_free;
    assign o_a_move     = a_move;
    assign i_item.ready = i_rst_n && (!r_in_vld || a_move);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_item.ready) begin
            r_in_vld <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.ready && i_item.valid) begin
            r_cmd    <= ssd_pkg::t_cmd'(i_item.cmd);
            r_slot   <= i_item.slot;
            r_symbol <= i_item.symbol;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scroll_delay  <= ssd_pkg::DELAY_RST;
            r_scroll_length <= ssd_pkg::LENGTH_RST;
        end else if (i_cfg_we) begin
            unique case (ssd_pkg::t_cfg_idx'(i_cfg_index))
                ssd_pkg::CFG_SCROLL_DELAY: begin
                    r_scroll_delay <= i_cfg_data[DELAY_W-1:0];
                end
                ssd_pkg::CFG_SCROLL_LENGTH: begin
                    r_scroll_length <= i_cfg_data[LEN_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        if (r_scroll_length < LEN_W'(ssd_pkg::NUM_DIGITS)) begin
            eff_len = LEN_W'(ssd_pkg::NUM_DIGITS);
        end else if (r_scroll_length > LEN_W'(ssd_pkg::TEXT_DEPTH)) begin
            eff_len = LEN_W'(ssd_pkg::TEXT_DEPTH);
        end else begin
            eff_len = r_scroll_length;
        end
    end

    assign end_pos   = eff_len - LEN_W'(ssd_pkg::NUM_DIGITS - 1);
    assign pos_inc   = LEN_W'(r_scroll_pos) + LEN_W'(1);
    assign pause_inc = r_pause_count + DELAY_W'(1);
    assign is_tick   = (r_cmd == ssd_pkg::CMD_TICK);
    assign do_step   = is_tick && r_scroll_on && !(pause_inc < r_scroll_delay);

    always_comb begin
        n_scroll_pos  = r_scroll_pos;
        n_pause_count = r_pause_count;
        n_scroll_on   = r_scroll_on;
        n_mux_digit   = r_mux_digit;
        unique case (r_cmd)
            ssd_pkg::CMD_TICK: begin
                n_mux_digit = r_mux_digit + DIGIT_W'(1);
                if (do_step) begin
                    n_pause_count = '0;
                    n_scroll_pos  = pos_inc[TEXT_AW-1:0];
                    n_scroll_on   = (pos_inc < end_pos);
                end else if (r_scroll_on) begin
                    n_pause_count = pause_inc;
                end
            end
            ssd_pkg::CMD_START: begin
                n_scroll_pos  = '0;
                n_pause_count = '0;
                n_scroll_on   = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scroll_pos  <= '0;
            r_pause_count <= '0;
            r_scroll_on   <= 1'b0;
            r_mux_digit   <= '0;
        end else if (a_move) begin
            r_scroll_pos  <= n_scroll_pos;
            r_pause_count <= n_pause_count;
            r_scroll_on   <= n_scroll_on;
            r_mux_digit   <= n_mux_digit;
        end
    end

    // window of consecutive symbols lands one per bank
    always_comb begin
        logic [DIGIT_W-1:0] off;
        logic [TEXT_AW-1:0] sum;
        o_mem.we    = a_move && (r_cmd == ssd_pkg::CMD_TEXT_WR);
        o_mem.wbank = r_slot[DIGIT_W-1:0];
        o_mem.waddr = r_slot[TEXT_AW-1:DIGIT_W];
        o_mem.wdata = r_symbol;
        o_mem.re    = a_move && do_step;
        for (int k = 0; k < ssd_pkg::NUM_DIGITS; k++) begin
            off            = DIGIT_W'(k) - r_scroll_pos[DIGIT_W-1:0];
            sum            = r_scroll_pos + TEXT_AW'(off);
            o_mem.raddr[k] = sum[TEXT_AW-1:DIGIT_W];
        end
    end

    always_comb begin
        o_stage.tick      = is_tick;
        o_stage.step      = do_step;
        o_stage.dwrite    = (r_cmd == ssd_pkg::CMD_DIGIT_WR)
                            && (r_slot < ssd_pkg::SLOT_W'(ssd_pkg::NUM_DIGITS));
        o_stage.scrolling = n_scroll_on;
        o_stage.digit     = r_mux_digit;
        o_stage.rot       = r_scroll_pos[DIGIT_W-1:0];
        o_stage.dslot     = r_slot[DIGIT_W-1:0];
        o_stage.symbol    = r_symbol;
    end

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_scroll_pos <= TEXT_AW'(ssd_pkg::TEXT_DEPTH - ssd_pkg::NUM_DIGITS + 1))
        else $error("scroll position past end of text");

    a_idle_pause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_scroll_on |-> (r_pause_count == '0))
        else $error("pause count nonzero while idle");

    a_idle_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_scroll_on && !(a_move && r_cmd == ssd_pkg::CMD_START))
        |=> $stable(r_scroll_pos))
        else $error("scroll position moved while idle");

endmodule

`default_nettype wire

// ----- hdl/ssd_digit_out.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ssd_digit_out (
    input  wire logic                                           i_clk,
    input  wire logic                                           i_rst_n,
    input  wire logic                                           i_a_move,
    input  wire ssd_pkg::t_stage                                i_stage,
    input  wire logic [ssd_pkg::NUM_DIGITS-1:0][ssd_pkg::SYM_W-1:0] i_rdata,
    output logic                                                o_b_free,
    ssd_out_if.source                                           o_result
);

    localparam int DIGIT_W = ssd_pkg::DIGIT_W;

    logic                  r_b_vld;
    ssd_pkg::t_stage       r_b;
    ssd_pkg::t_sym         r_digit [ssd_pkg::NUM_DIGITS];
    ssd_pkg::t_sym         n_digit [ssd_pkg::NUM_DIGITS];

    logic                  r_out_vld;
    logic [DIGIT_W-1:0]    r_out_digit;
    ssd_pkg::t_sym         r_out_seg;
    logic                  r_out_scroll;

    logic                  out_free;
    logic                  b_move;

    assign out_free = !r_out_vld || o_result.ready;
    assign b_move   = r_b_vld && (out_free || !r_b.tick);
    assign o_b_free = !r_b_vld || b_move;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (i_a_move) begin
            r_b_vld <= 1'b1;
        end else if (b_move) begin
            r_b_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_a_move) begin
            r_b <= i_stage;
        end
    end

    always_comb begin
        logic [DIGIT_W-1:0] idx;
        for (int i = 0; i < ssd_pkg::NUM_DIGITS; i++) begin
            idx        = r_b.rot + DIGIT_W'(i);
            n_digit[i] = r_digit[i];
            if (r_b.step) begin
                n_digit[i] = i_rdata[idx];
            end
            if (r_b.dwrite && (r_b.dslot == DIGIT_W'(i))) begin
                n_digit[i] = r_b.symbol;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ssd_pkg::NUM_DIGITS; i++) begin
                r_digit[i] <= '0;
            end
        end else if (b_move) begin
            for (int i = 0; i < ssd_pkg::NUM_DIGITS; i++) begin
                r_digit[i] <= n_digit[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (b_move && r_b.tick) begin
            r_out_vld <= 1'b1;
        end else if (o_result.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_move && r_b.tick) begin
            r_out_digit  <= r_b.digit;
            r_out_seg    <= n_digit[r_b.digit];
            r_out_scroll <= r_b.scrolling;
        end
    end

    assign o_result.valid       = r_out_vld;
    assign o_result.digit_index = r_out_digit;
    assign o_result.segments    = r_out_seg;
    assign o_result.scrolling   = r_out_scroll;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !o_result.ready) |-> !(b_move && r_b.tick))
        else $error("pending result overwritten");

    a_silent_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (b_move && !r_b.tick && out_free) |=> !r_out_vld)
        else $error("result raised by non-tick beat");

endmodule

`default_nettype wire

// ----- hdl/scrolling_seven_segment_driver.sv -----
// Path: an accepted beat passes through the input register, the text bank read
//   register and the output register. Throughput: one beat per cycle unless
//   o_result stalls a tick; ticks yield one result, other commands none.
// Reset (synchronous, active low) clears digits, scroll state and config to
//   their defaults; the text store is not cleared and holds garbage until written.
`timescale 1ns / 1ps
`default_nettype none

module scrolling_seven_segment_driver (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    ssd_in_if.sink                               i_item,
    ssd_out_if.source                            o_result,
    input  wire logic                            i_cfg_we,
    input  wire logic [ssd_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [ssd_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    logic                                                 a_move;
    logic                                                 b_free;
    ssd_pkg::t_mem_req                                    mem_req;
    ssd_pkg::t_stage                                      stage;
    logic [ssd_pkg::NUM_DIGITS-1:0][ssd_pkg::SYM_W-1:0]   rdata;

    ssd_scroll_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_b_free    (b_free),
        .o_a_move    (a_move),
        .o_mem       (mem_req),
        .o_stage     (stage)
    );

    for (genvar k = 0; k < ssd_pkg::NUM_DIGITS; k++) begin : g_bank
        ssd_bank_ram u_bank (
            .i_clk   (i_clk),
            .i_we    (mem_req.we && (mem_req.wbank == ssd_pkg::DIGIT_W'(k))),
            .i_waddr (mem_req.waddr),
            .i_wdata (mem_req.wdata),
            .i_re    (mem_req.re),
            .i_raddr (mem_req.raddr[k]),
            .o_rdata (rdata[k])
        );
    end

    ssd_digit_out u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_a_move (a_move),
        .i_stage  (stage),
        .i_rdata  (rdata),
        .o_b_free (b_free),
        .o_result (o_result)
    );

endmodule

`default_nettype wire
